// ===== hdl/bvts_pkg.sv =====
// ----------------------------------------------------------------------------
// bvts_pkg - shared types and constants for the content sniffer
// Transaction payload structs, register map and fixed field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bvts_pkg;

  // fixed widths of the transaction fields
  localparam int unsigned CNT_FIELD_W = 13;
  localparam int unsigned LIMIT_W     = 13;
  localparam int unsigned THRESH_W    = 7;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  // register map, selected by paddr[2]
  localparam logic REG_SCAN_LIMIT = 1'b0;
  localparam logic REG_THRESHOLD  = 1'b1;

  localparam logic [LIMIT_W-1:0]  SCAN_LIMIT_RST = 13'd4096;
  localparam logic [THRESH_W-1:0] THRESHOLD_RST  = 7'd90;

  // text test: printable * PCT_SCALE > threshold * scanned
  localparam int unsigned PCT_SCALE = 100;
  localparam int unsigned MIN_SCAN  = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_content;
  } bvts_in_t;

  typedef struct packed {
    logic                   is_binary;
    logic                   magic_matched;
    logic                   null_seen;
    logic [CNT_FIELD_W-1:0] printable_total;
    logic [CNT_FIELD_W-1:0] scanned_total;
  } bvts_out_t;

  // flags of a finished content, scanner to result stage
  typedef struct packed {
    logic null_seen;
    logic magic;
  } bvts_flags_t;

endpackage

// ===== hdl/bvts_scan.sv =====
// ----------------------------------------------------------------------------
// bvts_scan - per-byte scanner
// Header capture, zero detect, printable count and UTF-8 sequence tracking;
// holds the totals of a finished content until the result stage takes them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bvts_scan
  import bvts_pkg::*;
#(
  parameter int unsigned MAX_SCAN = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           acc,
  input  bvts_in_t                       item,
  input  logic [$clog2(MAX_SCAN+1)-1:0]  lim,
  output logic                           fin_valid,
  input  logic                           fin_take,
  output bvts_flags_t                    fin_flags,
  output logic [$clog2(MAX_SCAN+1)-1:0]  fin_cnt,
  output logic [$clog2(MAX_SCAN+1)-1:0]  fin_prt
);

  localparam int unsigned CW = $clog2(MAX_SCAN + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] prt_r, prt_nxt;
  logic [31:0]   hdr_r, hdr_nxt;
  logic [1:0]    pend_r, pend_nxt;
  logic [1:0]    rem_r, rem_nxt;
  logic          zero_r, zero_nxt;

  logic          fin_valid_r;
  bvts_flags_t   fin_flags_r;
  logic [CW-1:0] fin_cnt_r, fin_prt_r;

  logic          in_window;
  logic          fresh;
  logic [7:0]    b;

  function automatic logic hdr_match(input logic [31:0] h);
    logic [7:0] h0, h1, h2, h3;
    h0 = h[7:0];
    h1 = h[15:8];
    h2 = h[23:16];
    h3 = h[31:24];
    hdr_match =
      (h0 == 8'h7F && h1 == 8'h45 && h2 == 8'h4C && h3 == 8'h46) ||      // ELF
      (h0 == 8'hFE && h1 == 8'hED && h2 == 8'hFA &&
       (h3 == 8'hCE || h3 == 8'hCF)) ||                                   // Mach-O
      (h0 == 8'hCA && h1 == 8'hFE && h2 == 8'hBA && h3 == 8'hBE) ||      // fat
      (h0 == 8'h60 && h1 == 8'h34) ||                                     // VMD
      (h0 == 8'h50 && h1 == 8'h4B && h2 == 8'h03 && h3 == 8'h04) ||      // ZIP
      (h0 == 8'h1F && h1 == 8'h8B) ||                                     // GZIP
      (h0 == 8'hFF && h1 == 8'hD8 && h2 == 8'hFF) ||                      // JPEG
      (h0 == 8'h89 && h1 == 8'h50 && h2 == 8'h4E && h3 == 8'h47);        // PNG
  endfunction

  assign b         = item.data_byte;
  assign in_window = cnt_r < lim;

  always_comb begin
    cnt_nxt  = cnt_r;
    prt_nxt  = prt_r;
    hdr_nxt  = hdr_r;
    pend_nxt = pend_r;
    rem_nxt  = rem_r;
    zero_nxt = zero_r;
    fresh    = 1'b1;

    if (acc && item.has_byte) begin
      if (cnt_r < CW'(MIN_SCAN)) begin
        hdr_nxt[8*cnt_r[1:0] +: 8] = b;
      end
      if (in_window) begin
        cnt_nxt = cnt_r + 1'b1;
        if (rem_r != 2'd0) begin
          if (b[7:6] == 2'b10) begin
            fresh   = 1'b0;
            rem_nxt = rem_r - 2'd1;
            if (rem_r == 2'd1) begin
              prt_nxt  = prt_r + CW'(pend_r) + 1'b1;
              pend_nxt = 2'd0;
            end
          end else begin
            // broken sequence: drop it, judge this byte afresh
            pend_nxt = 2'd0;
            rem_nxt  = 2'd0;
          end
        end
        if (fresh) begin
          if (b == 8'h00) begin
            zero_nxt = 1'b1;
          end else if (b inside {[8'h20:8'h7E], 8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D}) begin
            prt_nxt = prt_r + 1'b1;
          end else if (b inside {[8'hC2:8'hDF]}) begin
            pend_nxt = 2'd1;
            rem_nxt  = 2'd1;
          end else if (b inside {[8'hE0:8'hEF]}) begin
            pend_nxt = 2'd2;
            rem_nxt  = 2'd2;
          end else if (b inside {[8'hF0:8'hF4]}) begin
            pend_nxt = 2'd3;
            rem_nxt  = 2'd3;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      prt_r       <= '0;
      hdr_r       <= '0;
      pend_r      <= '0;
      rem_r       <= '0;
      zero_r      <= 1'b0;
      fin_valid_r <= 1'b0;
    end else begin
      if (acc && item.end_of_content) begin
        cnt_r       <= '0;
        prt_r       <= '0;
        hdr_r       <= '0;
        pend_r      <= '0;
        rem_r       <= '0;
        zero_r      <= 1'b0;
        fin_valid_r <= 1'b1;
      end else begin
        cnt_r  <= cnt_nxt;
        prt_r  <= prt_nxt;
        hdr_r  <= hdr_nxt;
        pend_r <= pend_nxt;
        rem_r  <= rem_nxt;
        zero_r <= zero_nxt;
        if (fin_take) begin
          fin_valid_r <= 1'b0;
        end
      end
    end
  end

  // totals of the finished content
  always_ff @(posedge clk) begin
    if (acc && item.end_of_content) begin
      fin_cnt_r             <= cnt_nxt;
      fin_prt_r             <= prt_nxt;
      fin_flags_r.null_seen <= zero_nxt;
      fin_flags_r.magic     <= (cnt_nxt >= CW'(MIN_SCAN)) && hdr_match(hdr_nxt);
    end
  end

  assign fin_valid = fin_valid_r;
  assign fin_flags = fin_flags_r;
  assign fin_cnt   = fin_cnt_r;
  assign fin_prt   = fin_prt_r;

endmodule

// ===== hdl/binary_vs_text_content_sniffer_core.sv =====
// ----------------------------------------------------------------------------
// binary_vs_text_content_sniffer_core - binary / text content classifier
// Takes content one byte per transaction and returns one verdict per content:
// signature match on the first four bytes, zero-byte detect and printable
// share (ASCII, whitespace, complete UTF-8 sequences) over the scan window.
// ----------------------------------------------------------------------------
//
//   channel | ports                              | carries
//   --------+------------------------------------+-----------------------------
//   in      | in_valid, in_ready, in_data        | one byte, has_byte, end flag
//   out     | out_valid, out_ready, out_data     | verdict, flags and totals
//   cfg     | psel, penable, pwrite, paddr, ...  | scan_limit @0, threshold @4
//
// One input transaction per cycle while out_ready is high; the rate is set by
// the scanner's counter and UTF-8 tracker, which update once per byte.
// The verdict of a content passes through the scanner totals register, then
// the result register with the percent compare.
// Reset (synchronous, rst_n low) empties both stages and restores the
// register defaults; there is no clearing pass.
// A stalled output holds its transaction and the totals stage behind it; the
// input stalls only when both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_vs_text_content_sniffer_core
  import bvts_pkg::*;
#(
  parameter int unsigned MAX_SCAN = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // byte stream in
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bvts_in_t              in_data,
  // verdict out
  output logic                  out_valid,
  input  logic                  out_ready,
  output bvts_out_t             out_data,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // counters must hold the largest window itself
  localparam int unsigned CW = $clog2(MAX_SCAN + 1);
  // width of the two products in the percent compare
  localparam int unsigned PW = CW + THRESH_W;

  logic [LIMIT_W-1:0]  scan_limit_r;
  logic [THRESH_W-1:0] threshold_r;
  logic [CW-1:0]       lim_r;

  logic                cfg_wr;
  logic                in_acc;

  logic                fin_valid;
  logic                fin_take;
  bvts_flags_t         fin_flags;
  logic [CW-1:0]       fin_cnt;
  logic [CW-1:0]       fin_prt;

  logic [PW-1:0]       lhs, rhs;
  logic                text;
  bvts_out_t           res;

  logic                out_valid_r;
  bvts_out_t           out_data_r;

  // clamp the programmed window to MIN_SCAN..MAX_SCAN
  function automatic logic [CW-1:0] clamp_lim(input logic [LIMIT_W-1:0] v);
    int unsigned w;
    w = int'(v);
    if (w < MIN_SCAN) begin
      w = MIN_SCAN;
    end else if (w > MAX_SCAN) begin
      w = MAX_SCAN;
    end
    clamp_lim = CW'(w);
  endfunction

  // --------------------------------------------------------------------------
  // Register port: zero wait states, write lands on the access phase.
  // The clamped window is worked out at write time so the scanner sees a
  // ready-made limit on the very next byte.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_limit_r <= SCAN_LIMIT_RST;
      threshold_r  <= THRESHOLD_RST;
      lim_r        <= clamp_lim(SCAN_LIMIT_RST);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SCAN_LIMIT: begin
          scan_limit_r <= pwdata[LIMIT_W-1:0];
          lim_r        <= clamp_lim(pwdata[LIMIT_W-1:0]);
        end
        REG_THRESHOLD: begin
          threshold_r <= pwdata[THRESH_W-1:0];
        end
        default: begin
          scan_limit_r <= scan_limit_r;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SCAN_LIMIT: prdata = APB_DATA_W'(scan_limit_r);
      REG_THRESHOLD:  prdata = APB_DATA_W'(threshold_r);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control. The totals stage drains into the result register whenever
  // that register is empty or being read; the scanner takes a byte whenever
  // its totals stage is free or draining in the same cycle.
  // --------------------------------------------------------------------------
  assign fin_take = fin_valid && (!out_valid_r || out_ready);
  assign in_ready = !fin_valid || fin_take;
  assign in_acc   = in_valid && in_ready;

  bvts_scan #(
    .MAX_SCAN (MAX_SCAN)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .item      (in_data),
    .lim       (lim_r),
    .fin_valid (fin_valid),
    .fin_take  (fin_take),
    .fin_flags (fin_flags),
    .fin_cnt   (fin_cnt),
    .fin_prt   (fin_prt)
  );

  // --------------------------------------------------------------------------
  // Verdict: text when printable*100 > threshold*scanned, empty content is
  // text. Two narrow products (one by a constant) and a compare.
  // --------------------------------------------------------------------------
  always_comb begin
    lhs  = PW'(fin_prt) * PW'(PCT_SCALE);
    rhs  = PW'(threshold_r) * PW'(fin_cnt);
    text = (fin_cnt == '0) || (lhs > rhs);

    res.magic_matched   = fin_flags.magic;
    res.null_seen       = fin_flags.null_seen;
    res.is_binary       = fin_flags.magic || fin_flags.null_seen || !text;
    res.printable_total = CNT_FIELD_W'(fin_prt);
    res.scanned_total   = CNT_FIELD_W'(fin_cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/bvts_checker.sv =====
// ----------------------------------------------------------------------------
// bvts_checker - port-level checks for the content sniffer
// Watches the result channel only; attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bvts_checker
  import bvts_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input bvts_out_t out_data
);

  // a stalled verdict holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("verdict dropped or changed while stalled");

  // a signature or zero byte always forces binary
  a_bin_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.magic_matched || out_data.null_seen) |-> out_data.is_binary)
    else $error("binary flag missing");

  // printable bytes never outnumber the scanned ones, and a signature needs four
  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.printable_total <= out_data.scanned_total) &&
                  (!out_data.magic_matched || out_data.scanned_total >= CNT_FIELD_W'(MIN_SCAN)))
    else $error("inconsistent totals");

  // empty content is text with nothing counted
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.scanned_total == '0 |->
      !out_data.is_binary && !out_data.null_seen && out_data.printable_total == '0)
    else $error("empty content not reported as text");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind binary_vs_text_content_sniffer_core bvts_checker u_bvts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
